// ===== src/rrbw_pkg.sv =====
package rrbw_pkg;

  localparam int unsigned MaxFrameBytesDef = 1518;
  localparam int unsigned MinFrameBytesDef = 60;
  localparam int unsigned HdrBytes = 4;

  localparam int unsigned PageW = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW = 11;
  localparam int unsigned CntW = 32;

  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 136;
  localparam int unsigned OutUserW = 3;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [PageW-1:0] RingStartRst = 8'd70;
  localparam logic [PageW-1:0] RingStopRst = 8'd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RING_START = 2'd0,
    CFG_RING_STOP  = 2'd1,
    CFG_RX_UP      = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [OutUserW-1:0] {
    KIND_EMPTY    = 3'd0,
    KIND_BAD_LEN  = 3'd1,
    KIND_BAD_NEXT = 3'd2,
    KIND_OVERRUN  = 3'd3,
    KIND_ACCEPTED = 3'd4,
    KIND_SKIPPED  = 3'd5
  } kind_e;

  localparam int unsigned StatusOkBit = 0;
  localparam int unsigned StatusOverrunBit = 3;

  typedef struct packed {
    logic [PageW-1:0] first_pg;
    logic [PageW-1:0] end_pg;
    logic             rx_up;
  } cfg_t;

  typedef struct packed {
    logic [PageW-1:0] boundary;
    logic [CntW-1:0]  accepted;
    logic [CntW-1:0]  overruns;
  } walk_state_t;

  typedef struct packed {
    logic [PageW-1:0]  write_page;
    logic [7:0]        status;
    logic [PageW-1:0]  next_page;
    logic [CountW-1:0] byte_count;
  } hdr_t;

  typedef struct packed {
    kind_e             kind;
    logic [AddrW-1:0]  first_addr;
    logic [LenW-1:0]   first_len;
    logic [AddrW-1:0]  second_addr;
    logic [LenW-1:0]   second_len;
    logic [PageW-1:0]  new_boundary;
    logic [PageW-1:0]  fetch_page;
    logic [CntW-1:0]   accepted_count;
    logic [CntW-1:0]   overrun_count;
  } result_t;

  // The page after the boundary, folded back to the ring start at the ring end.
  function automatic logic [PageW-1:0] page_after(input logic [PageW-1:0] b,
                                                  input cfg_t cfg);
    logic [PageW-1:0] p;
    p = b + 8'd1;
    if (p == cfg.end_pg) begin
      p = cfg.first_pg;
    end
    return p;
  endfunction

endpackage

// ===== src/rrbw_classify.sv =====
module rrbw_classify #(
  parameter int unsigned MAX_FRAME_BYTES = rrbw_pkg::MaxFrameBytesDef,
  parameter int unsigned MIN_FRAME_BYTES = rrbw_pkg::MinFrameBytesDef
) (
  input  rrbw_pkg::cfg_t        cfg_i,
  input  rrbw_pkg::walk_state_t state_i,
  input  rrbw_pkg::hdr_t        hdr_i,
  output rrbw_pkg::walk_state_t state_o,
  output rrbw_pkg::result_t     res_o
);

  localparam logic [16:0] MinCount = 17'(rrbw_pkg::HdrBytes + MIN_FRAME_BYTES);
  localparam logic [16:0] MaxCount = 17'(rrbw_pkg::HdrBytes + MAX_FRAME_BYTES);

  logic [rrbw_pkg::PageW-1:0]  fetch;
  logic [rrbw_pkg::PageW-1:0]  next;
  logic [rrbw_pkg::CountW-1:0] len;
  logic [16:0]                 base;
  logic [16:0]                 stopb;
  logic [17:0]                 frame_end;
  logic [16:0]                 l1;
  logic [16:0]                 l2;
  logic                        bad_len;
  logic                        bad_next;

  assign fetch = rrbw_pkg::page_after(state_i.boundary, cfg_i);
  assign len = (hdr_i.byte_count >= 16'(rrbw_pkg::HdrBytes))
             ? hdr_i.byte_count - 16'(rrbw_pkg::HdrBytes) : '0;
  assign bad_len = ({1'b0, hdr_i.byte_count} < MinCount) ||
                   ({1'b0, hdr_i.byte_count} > MaxCount);
  assign bad_next = (hdr_i.next_page < cfg_i.first_pg) ||
                    (hdr_i.next_page > cfg_i.end_pg);

  assign base = {1'b0, fetch, 8'd0} + 17'(rrbw_pkg::HdrBytes);
  assign stopb = {1'b0, cfg_i.end_pg, 8'd0};
  assign frame_end = {1'b0, base} + {2'b00, len};

  always_comb begin
    state_o = state_i;
    res_o = '0;
    res_o.kind = rrbw_pkg::KIND_EMPTY;
    next = hdr_i.next_page;
    l1 = '0;
    l2 = '0;
    if (fetch != hdr_i.write_page) begin
      if (bad_len) begin
        res_o.kind = rrbw_pkg::KIND_BAD_LEN;
        next = hdr_i.write_page;
      end else if (bad_next) begin
        res_o.kind = rrbw_pkg::KIND_BAD_NEXT;
        next = hdr_i.write_page;
      end else if (hdr_i.status[rrbw_pkg::StatusOverrunBit]) begin
        res_o.kind = rrbw_pkg::KIND_OVERRUN;
        next = hdr_i.write_page;
        state_o.overruns = state_i.overruns + 32'd1;
      end else if (hdr_i.status[rrbw_pkg::StatusOkBit] && cfg_i.rx_up) begin
        res_o.kind = rrbw_pkg::KIND_ACCEPTED;
        res_o.first_addr = base[rrbw_pkg::AddrW-1:0];
        if (frame_end > {1'b0, stopb}) begin
          // The frame runs past the ring end and continues at the ring start.
          l1 = (stopb > base) ? stopb - base : '0;
          l2 = {1'b0, len} - l1;
          res_o.second_addr = {cfg_i.first_pg, 8'd0};
        end else begin
          l1 = {1'b0, len};
        end
        state_o.accepted = state_i.accepted + 32'd1;
      end else begin
        res_o.kind = rrbw_pkg::KIND_SKIPPED;
      end
      if (next == cfg_i.first_pg) begin
        state_o.boundary = cfg_i.end_pg - 8'd1;
      end else begin
        state_o.boundary = next - 8'd1;
      end
    end
    res_o.first_len = l1[rrbw_pkg::LenW-1:0];
    res_o.second_len = l2[rrbw_pkg::LenW-1:0];
    res_o.new_boundary = state_o.boundary;
    res_o.fetch_page = rrbw_pkg::page_after(state_o.boundary, cfg_i);
    res_o.accepted_count = state_o.accepted;
    res_o.overrun_count = state_o.overruns;
  end

endmodule

// ===== src/rrbw_out_reg.sv =====
module rrbw_out_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  rrbw_pkg::result_t                   res_i,
  output logic                                ready_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // first_addr, first_len, second_addr, second_len, new_boundary, fetch_page,
  // accepted_count, overrun_count, then two zero bits
  output logic [rrbw_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // frame_kind
  output logic [rrbw_pkg::OutUserW-1:0]       m_axis_tuser_o
);

  logic              vld_q, vld_d;
  rrbw_pkg::result_t res_q;

  assign ready_o = !vld_q || m_axis_tready_i;
  assign vld_d = load_i || (vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tuser_o = res_q.kind;
  assign m_axis_tdata_o = {2'b00, res_q.overrun_count, res_q.accepted_count,
                           res_q.fetch_page, res_q.new_boundary, res_q.second_len,
                           res_q.second_addr, res_q.first_len, res_q.first_addr};

endmodule

// ===== src/rx_ring_boundary_walker.sv =====
// Receive ring boundary walker: consumer side of a paged receive ring.
// Each input beat on s_axis carries the page the receiver writes next and the
// four-byte frame header read at the page last reported as fetch_page. Each
// input beat yields exactly one output beat on m_axis: the frame kind in
// tuser, and the copy segments, new boundary, next fetch page and running
// accepted and overrun counts in tdata.
// An input beat is captured in an input register and classified by a short
// block of logic into the output register, which takes the result once it is
// free or its beat is taken. One beat per cycle is sustained while
// m_axis_tready_i stays high; the boundary and counter registers update as
// each result is loaded, so the following header is classified against the
// updated boundary at once. Ring start, ring stop and receiver up are written
// through cfg_we_i, which the user must do only while no beat is in flight;
// the block does not enforce it. Writes to the unused index are ignored.
// After reset the ring spans pages 70 to 127, the receiver is down, the
// boundary sits at page 70, both counters are zero and no beat is pending.
// When m_axis_tready_i is low the output holds its beat, one further beat
// waits in the input register, and s_axis_tready_o then falls.
module rx_ring_boundary_walker #(
  parameter int unsigned MAX_FRAME_BYTES = rrbw_pkg::MaxFrameBytesDef,
  parameter int unsigned MIN_FRAME_BYTES = rrbw_pkg::MinFrameBytesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rrbw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rrbw_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // write_page, header_status, header_next_page, header_byte_count
  input  logic [rrbw_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // first_addr, first_len, second_addr, second_len, new_boundary, fetch_page,
  // accepted_count, overrun_count, then two zero bits
  output logic [rrbw_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // frame_kind
  output logic [rrbw_pkg::OutUserW-1:0]     m_axis_tuser_o
);

  rrbw_pkg::cfg_t        cfg_q, cfg_d;
  rrbw_pkg::walk_state_t state_q, state_d;
  rrbw_pkg::hdr_t        hdr_q;
  rrbw_pkg::result_t     res;
  logic                  in_vld_q, in_vld_d;
  logic                  out_ready;
  logic                  adv;
  logic                  in_take;

  assign adv = in_vld_q && out_ready;
  assign s_axis_tready_o = !in_vld_q || out_ready;
  assign in_take = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vld_d = in_take || (in_vld_q && !out_ready);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrbw_pkg::CFG_RING_START: cfg_d.first_pg = cfg_wdata_i;
        rrbw_pkg::CFG_RING_STOP:  cfg_d.end_pg = cfg_wdata_i;
        rrbw_pkg::CFG_RX_UP:      cfg_d.rx_up = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_pg <= rrbw_pkg::RingStartRst;
      cfg_q.end_pg <= rrbw_pkg::RingStopRst;
      cfg_q.rx_up <= 1'b0;
      state_q.boundary <= rrbw_pkg::RingStartRst;
      state_q.accepted <= '0;
      state_q.overruns <= '0;
      in_vld_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      in_vld_q <= in_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hdr_q.write_page <= s_axis_tdata_i[7:0];
      hdr_q.status <= s_axis_tdata_i[15:8];
      hdr_q.next_page <= s_axis_tdata_i[23:16];
      hdr_q.byte_count <= s_axis_tdata_i[39:24];
    end
  end

  rrbw_classify #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_classify (
    .cfg_i  (cfg_q),
    .state_i(state_q),
    .hdr_i  (hdr_q),
    .state_o(state_d),
    .res_o  (res)
  );

  rrbw_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (adv),
    .res_i          (res),
    .ready_o        (out_ready),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rrbw_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam logic [7:0] StsOk = 8'h01;
  localparam logic [7:0] StsOverrun = 8'h08;
  localparam logic [7:0] StsNone = 8'hF6;

  // Predicts every result beat from the headers accepted so far and holds the queue
  // of results still to come.
  class ring_scoreboard;
    logic [PageW-1:0] start_pg;
    logic [PageW-1:0] stop_pg;
    logic             rx_up;
    logic [PageW-1:0] boundary;
    logic [CntW-1:0]  acc_total;
    logic [CntW-1:0]  ovr_total;
    result_t          result_q[$];
    int               errors;

    function new();
      start_pg  = RingStartRst;
      stop_pg   = RingStopRst;
      rx_up     = 1'b0;
      boundary  = RingStartRst;
      acc_total = '0;
      ovr_total = '0;
      errors    = 0;
    endfunction

    function logic [PageW-1:0] step_page(logic [PageW-1:0] b);
      logic [PageW-1:0] p;
      p = b + 8'd1;
      if (p == stop_pg) begin
        p = start_pg;
      end
      return p;
    endfunction

    function logic [PageW-1:0] fetch_now();
      return step_page(boundary);
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_RING_START: start_pg = val;
        CFG_RING_STOP:  stop_pg = val;
        CFG_RX_UP:      rx_up = val[0];
        default: ;
      endcase
    endfunction

    function void note_header(hdr_t h);
      result_t          r;
      logic [PageW-1:0] fetch;
      logic [PageW-1:0] nxt_pg;
      logic [31:0]      cnt;
      logic [31:0]      len;
      logic [31:0]      base;
      logic [31:0]      stopb;
      logic [31:0]      l1;
      logic [31:0]      l2;
      r = '0;
      r.kind = KIND_EMPTY;
      fetch = step_page(boundary);
      if (fetch != h.write_page) begin
        nxt_pg = h.next_page;
        cnt = 32'(h.byte_count);
        len = (cnt >= HdrBytes) ? cnt - HdrBytes : 32'd0;
        if (cnt < HdrBytes + MinFrameBytesDef || cnt > HdrBytes + MaxFrameBytesDef) begin
          r.kind = KIND_BAD_LEN;
          nxt_pg = h.write_page;
        end else if (h.next_page < start_pg || h.next_page > stop_pg) begin
          r.kind = KIND_BAD_NEXT;
          nxt_pg = h.write_page;
        end else if (h.status[StatusOverrunBit]) begin
          r.kind = KIND_OVERRUN;
          nxt_pg = h.write_page;
          ovr_total = ovr_total + 32'd1;
        end else if (h.status[StatusOkBit] && rx_up) begin
          r.kind = KIND_ACCEPTED;
          base = 32'(fetch) * 32'd256 + HdrBytes;
          stopb = 32'(stop_pg) * 32'd256;
          r.first_addr = base[AddrW-1:0];
          if (base + len > stopb) begin
            // The frame runs past the ring end and continues at the ring start.
            l1 = (stopb > base) ? stopb - base : 32'd0;
            l2 = len - l1;
            r.first_len = l1[LenW-1:0];
            r.second_len = l2[LenW-1:0];
            base = 32'(start_pg) * 32'd256;
            r.second_addr = base[AddrW-1:0];
          end else begin
            r.first_len = len[LenW-1:0];
          end
          acc_total = acc_total + 32'd1;
        end else begin
          r.kind = KIND_SKIPPED;
        end
        boundary = (nxt_pg == start_pg) ? stop_pg - 8'd1 : nxt_pg - 8'd1;
      end
      r.new_boundary = boundary;
      r.fetch_page = step_page(boundary);
      r.accepted_count = acc_total;
      r.overrun_count = ovr_total;
      result_q.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(logic [OutDataW-1:0] d, logic [OutUserW-1:0] u);
      result_t e;
      if (result_q.size() == 0) begin
        $error("result beat with no prediction waiting: tuser %0h", u);
        errors++;
        return;
      end
      e = result_q.pop_front();
      cmp("frame_kind", 32'(e.kind), 32'(u));
      cmp("first_addr", 32'(e.first_addr), 32'(d[15:0]));
      cmp("first_len", 32'(e.first_len), 32'(d[26:16]));
      cmp("second_addr", 32'(e.second_addr), 32'(d[42:27]));
      cmp("second_len", 32'(e.second_len), 32'(d[53:43]));
      cmp("new_boundary", 32'(e.new_boundary), 32'(d[61:54]));
      cmp("fetch_page", 32'(e.fetch_page), 32'(d[69:62]));
      cmp("accepted_count", e.accepted_count, d[101:70]);
      cmp("overrun_count", e.overrun_count, d[133:102]);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_RING_START;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;

  ring_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  bit             no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  rx_ring_boundary_walker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rx_ring_boundary_walker: mismatch");
      $finish;
    end
  end

  // Result side: checks each beat and stalls at random, with one long hold-off
  // that fills the block up, and one stretch with no stalls at all.
  initial begin : result_sink
    int beats;
    int stall_left;
    int r;
    bit held;
    beats = 0;
    stall_left = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_beat(m_axis_tdata_o, m_axis_tuser_o);
        beats++;
      end
      if (!held && beats == 400) begin
        held = 1'b1;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (beats >= 800 && beats < 1000) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= 1'b0;
          stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(8, 60);
        end
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) begin
      return 0;
    end
    return (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 40);
  endfunction

  // Offers one header beat and returns at the edge that accepts it. The valid is
  // left high so that a back-to-back beat never lowers and raises it in one step.
  task automatic send_hdr(input hdr_t h);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {h.byte_count, h.next_page, h.status, h.write_page};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_header(h);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_ring(input logic [7:0] start_pg, input logic [7:0] stop_pg,
                              input logic rx_up, input bit poke_unused);
    logic [7:0] junk;
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_RING_START;
    cfg_wdata_i <= start_pg;
    @(posedge clk_i);
    sb.write_reg(CFG_RING_START, start_pg);
    cfg_idx_i <= CFG_RING_STOP;
    cfg_wdata_i <= stop_pg;
    @(posedge clk_i);
    sb.write_reg(CFG_RING_STOP, stop_pg);
    cfg_idx_i <= CFG_RX_UP;
    cfg_wdata_i <= {7'($urandom), rx_up};
    @(posedge clk_i);
    sb.write_reg(CFG_RX_UP, {7'd0, rx_up});
    if (poke_unused) begin
      junk = 8'($urandom);
      cfg_idx_i <= CFG_UNUSED;
      cfg_wdata_i <= junk;
      @(posedge clk_i);
      sb.write_reg(CFG_UNUSED, junk);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly headers that follow the ring as a receiver would write it, with random
  // content, and some fully random noise.
  function automatic hdr_t make_header();
    hdr_t       h;
    logic [7:0] f;
    logic [7:0] lo;
    logic [7:0] hi;
    int         r;
    f = sb.fetch_now();
    lo = sb.start_pg;
    hi = sb.stop_pg;
    if ($urandom_range(0, 99) < 15) begin
      h.write_page = 8'($urandom);
      h.status = 8'($urandom);
      h.next_page = 8'($urandom);
      h.byte_count = 16'($urandom);
      return h;
    end
    h.write_page = ($urandom_range(0, 99) < 10) ? f : f + 8'($urandom_range(1, 255));
    h.status = 8'($urandom) & StsNone;
    h.status[StatusOkBit] = ($urandom_range(0, 99) < 85);
    h.status[StatusOverrunBit] = ($urandom_range(0, 99) < 8);
    if (lo <= hi && $urandom_range(0, 99) < 90) begin
      h.next_page = 8'($urandom_range(lo, hi));
    end else begin
      h.next_page = 8'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: h.byte_count = 16'd63;
        1: h.byte_count = 16'd64;
        2: h.byte_count = 16'd1522;
        default: h.byte_count = 16'd1523;
      endcase
    end else if (r < 92) begin
      h.byte_count = 16'($urandom_range(64, 1522));
    end else begin
      h.byte_count = 16'($urandom);
    end
    return h;
  endfunction

  task automatic run_phase(input int n);
    repeat (n) send_hdr(make_header());
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the receiver down a good frame is only skipped.
    send_hdr(hdr_t'{sb.fetch_now() + 8'd1, StsOk, 8'd80, 16'd100});
    program_ring(8'd70, 8'd128, 1'b1, 1'b1);
    send_hdr(hdr_t'{sb.fetch_now(), StsOk, 8'd90, 16'd100});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd90, 16'd0});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd90, 16'd3});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd90, 16'd63});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd90, 16'd64});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd100, 16'd1522});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd100, 16'd1523});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd100, 16'hFFFF});
    send_hdr(hdr_t'{8'd255, StsOk, 8'd69, 16'd200});
    send_hdr(hdr_t'{8'd0, StsOk, 8'd129, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd0, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd255, 16'd200});
    // A next pointer at the stop page folds the fetch page back to the ring start.
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd128, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd70, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk | StsOverrun, 8'd90, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOverrun, 8'd90, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, 8'hFF, 8'd90, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsNone, 8'd90, 16'd200});
    // A full-size frame from the last page of the ring wraps to the ring start.
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd127, 16'd200});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd80, 16'd1522});
    // An error leaves the fetch page beyond the ring end, so the whole frame wraps.
    send_hdr(hdr_t'{8'd200, StsOk, 8'd90, 16'd10});
    send_hdr(hdr_t'{sb.fetch_now() + 8'd3, StsOk, 8'd80, 16'd100});

    program_ring(8'd0, 8'd255, 1'b1, 1'b0);
    run_phase(250);
    program_ring(8'd0, 8'd1, 1'b1, 1'b0);
    run_phase(150);
    program_ring(8'd10, 8'd20, 1'b1, 1'b1);
    run_phase(220);
    program_ring(8'd254, 8'd255, 1'b1, 1'b0);
    run_phase(150);
    program_ring(8'd255, 8'd255, 1'b1, 1'b0);
    run_phase(100);
    program_ring(8'd200, 8'd100, 1'b1, 1'b0);
    run_phase(150);
    program_ring(8'd70, 8'd128, 1'b0, 1'b0);
    run_phase(150);
    no_gaps = 1'b1;
    program_ring(8'd30, 8'd200, 1'b1, 1'b0);
    run_phase(250);
    no_gaps = 1'b0;
    program_ring(8'd1, 8'd3, 1'b1, 1'b1);
    run_phase(120);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rx_ring_boundary_walker: match");
    end else begin
      $display("rx_ring_boundary_walker: mismatch");
    end
    $finish;
  end

endmodule
